### design/krt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Sizes, operation and status codes, payload structs and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned COURSES    = 4;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PACK_BYTES = (COURSES < 4) ? COURSES : 4;
  localparam logic [31:0] PACK_MASK  =
    (PACK_BYTES == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * PACK_BYTES)) - 32'd1);
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // Operation codes
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_LIST   = 2'd3
  } krt_mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } krt_status_e;

  // Fill state codes
  typedef enum logic [1:0] {
    FILL_EMPTY   = 2'd0,
    FILL_PARTIAL = 2'd1,
    FILL_FULL    = 2'd2
  } krt_fill_e;

  // Input transfer payload
  typedef struct packed {
    krt_mode_e   mode;
    logic [7:0]  key;
    logic [7:0]  year_in;
    logic [31:0] courses_in;
    logic [31:0] grades_in;
  } krt_in_t;

  // Output transfer payload
  typedef struct packed {
    krt_status_e      status;
    logic [7:0]       year_out;
    logic [31:0]      courses_out;
    logic [31:0]      grades_out;
    logic [7:0]       listed_key;
    logic             last;
    logic [CNT_W-1:0] used_count;
    krt_fill_e        fill_state;
  } krt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the accepted input item
    logic find;    // register the key search result
    logic exec;    // apply the operation and load the output register
  } krt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    krt_mode_e mode;
    logic      empty;
    logic      list_last;
    logic      out_free;
  } krt_sts_t;

endpackage
`default_nettype wire

### design/keyed_record_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table_top: bounded table of keyed records in insertion order
// Add, delete, read by key and list keys, with count and fill state reported
// on every result.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY records, each a key, a year byte and packed
// course and grade bytes, all in flip-flops; the records are not cleared at
// reset, only the record count is. One item is taken at a time: an accepted
// item is captured, then goes through the registered parallel key search and
// then the execute step, which waits while the output side is stalled. List
// repeats the execute step once per stored key and emits one key per cycle
// while the output side is not stalled (a single step on an empty table).
// Delete closes the gap by shifting all later records down in the execute
// step. The result sits in an output register, and the next item is accepted
// while it waits.
// ----------------------------------------------------------------------------
module keyed_record_table_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire krt_pkg::krt_in_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output krt_pkg::krt_out_t     out_o
);
  import krt_pkg::*;

  krt_cmd_t cmd;
  krt_sts_t sts;

  // Sequencer
  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and results
  krt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

### design/krt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ctrl: operation sequencer of the keyed record table
// Accepts one item, steps it through search and execute, and repeats the
// execute step once per record while listing.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire krt_pkg::krt_sts_t sts_i,
  output krt_pkg::krt_cmd_t      cmd_o
);
  import krt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIND = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       more;

  // A non-empty list keeps executing until its final key goes out
  assign more = (sts_i.mode == MODE_LIST) && !sts_i.empty && !sts_i.list_last;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          if (!more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### design/krt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_dp: record storage and result datapath of the keyed record table
// Holds the slot registers and the record count, searches all keys in
// parallel, shifts on delete and drives the output register.
// ----------------------------------------------------------------------------
module krt_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire krt_pkg::krt_in_t  in_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output krt_pkg::krt_out_t      out_o,
  input  wire krt_pkg::krt_cmd_t cmd_i,
  output krt_pkg::krt_sts_t      sts_o
);
  import krt_pkg::*;

  // Slot storage, undefined until written
  logic [7:0]  slot_key_q     [CAPACITY];
  logic [7:0]  slot_year_q    [CAPACITY];
  logic [31:0] slot_courses_q [CAPACITY];
  logic [31:0] slot_grades_q  [CAPACITY];

  logic [CNT_W-1:0] count_q, count_d;
  krt_in_t          op_q, in_masked;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] list_idx_q;
  logic             out_valid_q;
  krt_out_t         out_q, res;

  logic             empty, full, list_last, add_en, del_en;
  logic [IDX_W-1:0] add_idx;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CAP_COUNT);
  assign list_last = ((CNT_W'(list_idx_q) + CNT_W'(1)) == count_q);
  assign add_idx   = count_q[IDX_W-1:0];
  assign add_en    = cmd_i.exec && (op_q.mode == MODE_ADD) && !full;
  assign del_en    = cmd_i.exec && (op_q.mode == MODE_DELETE) && !empty && found_q;

  // Input item with only the kept course and grade bytes
  always_comb begin
    in_masked            = in_i;
    in_masked.courses_in = in_i.courses_in & PACK_MASK;
    in_masked.grades_in  = in_i.grades_in & PACK_MASK;
  end

  // Parallel key compare over held records, lowest index wins
  always_comb begin
    match_idx_d = '0;
    found_d     = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((slot_key_q[i] == op_q.key) && (CNT_W'(i) < count_q)) begin
        match_idx_d = IDX_W'(i);
        found_d     = 1'b1;
      end
    end
  end

  // Result of the current execute step
  always_comb begin
    res            = '0;
    res.status     = STATUS_OK;
    res.last       = 1'b1;
    count_d        = count_q;
    unique case (op_q.mode)
      MODE_ADD: begin
        if (full) begin
          res.status = STATUS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (empty) begin
          res.status = STATUS_EMPTY;
        end else if (!found_q) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (empty) begin
          res.status = STATUS_EMPTY;
        end else if (!found_q) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          res.year_out    = slot_year_q[match_idx_q];
          res.courses_out = slot_courses_q[match_idx_q];
          res.grades_out  = slot_grades_q[match_idx_q];
        end
      end
      MODE_LIST: begin
        if (empty) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.listed_key = slot_key_q[list_idx_q];
          res.last       = list_last;
        end
      end
      default: begin
        res.status = STATUS_OK;
      end
    endcase
    res.used_count = count_d;
    if (count_d == '0) begin
      res.fill_state = FILL_EMPTY;
    end else if (count_d == CAP_COUNT) begin
      res.fill_state = FILL_FULL;
    end else begin
      res.fill_state = FILL_PARTIAL;
    end
  end

  // Slot writes: append at the tail, or close the gap on delete
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (add_en && (add_idx == IDX_W'(i))) begin
        slot_key_q[i]     <= op_q.key;
        slot_year_q[i]    <= op_q.year_in;
        slot_courses_q[i] <= op_q.courses_in;
        slot_grades_q[i]  <= op_q.grades_in;
      end
    end
    for (int j = 0; j < CAPACITY - 1; j++) begin
      if (del_en && (IDX_W'(j) >= match_idx_q)) begin
        slot_key_q[j]     <= slot_key_q[j+1];
        slot_year_q[j]    <= slot_year_q[j+1];
        slot_courses_q[j] <= slot_courses_q[j+1];
        slot_grades_q[j]  <= slot_grades_q[j+1];
      end
    end
  end

  // Operand and search result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= in_masked;
    end
    if (cmd_i.find) begin
      match_idx_q <= match_idx_d;
      found_q     <= found_d;
    end
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  // Count, list position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
      if (cmd_i.latch) begin
        list_idx_q <= '0;
      end else if (cmd_i.exec && (op_q.mode == MODE_LIST)) begin
        list_idx_q <= list_idx_q + IDX_W'(1);
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;
  assign sts_o.mode      = op_q.mode;
  assign sts_o.empty     = empty;
  assign sts_o.list_last = list_last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

### verif/krt_checker.sv
// ----------------------------------------------------------------------------
// krt_checker: result checker for the keyed record table
// Keeps a shadow copy of the table, updated from every accepted input
// transfer. Predicts the results each operation causes, then compares every
// accepted output transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module krt_checker
  import krt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  krt_in_t     in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  krt_out_t    out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the table contents
  logic [7:0]  shadow_key     [CAPACITY];
  logic [7:0]  shadow_year    [CAPACITY];
  logic [31:0] shadow_courses [CAPACITY];
  logic [31:0] shadow_grades  [CAPACITY];
  int          shadow_count;

  krt_out_t    expected_results_q [$];
  int unsigned result_index;

  // Count and fill state as they stand after the operation
  function automatic krt_out_t stamp_occupancy(krt_out_t r);
    r.used_count = CNT_W'(shadow_count);
    if (shadow_count == 0) begin
      r.fill_state = FILL_EMPTY;
    end else if (shadow_count >= CAPACITY) begin
      r.fill_state = FILL_FULL;
    end else begin
      r.fill_state = FILL_PARTIAL;
    end
    return r;
  endfunction

  // Apply one operation to the shadow table and queue its results
  function automatic void predict_table_op(krt_in_t cmd);
    krt_out_t r;
    int       hit;
    int       i;
    r      = '0;
    r.last = 1'b1;
    hit    = -1;
    case (cmd.mode)
      MODE_ADD: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_key[shadow_count]     = cmd.key;
          shadow_year[shadow_count]    = cmd.year_in;
          shadow_courses[shadow_count] = cmd.courses_in & PACK_MASK;
          shadow_grades[shadow_count]  = cmd.grades_in & PACK_MASK;
          shadow_count++;
          r.status = STATUS_OK;
        end
      end
      MODE_LIST: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // one transfer per stored key, last flag on the final one
          for (i = 0; i < shadow_count; i++) begin
            r.status     = STATUS_OK;
            r.listed_key = shadow_key[i];
            r.last       = (i + 1 == shadow_count);
            expected_results_q.push_back(stamp_occupancy(r));
          end
          return;
        end
      end
      default: begin
        // delete and read act on the first matching key only
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_key[i] == cmd.key) hit = i;
        end
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else if (cmd.mode == MODE_READ) begin
          r.status      = STATUS_OK;
          r.year_out    = shadow_year[hit];
          r.courses_out = shadow_courses[hit];
          r.grades_out  = shadow_grades[hit];
        end else begin
          // close the gap left by the removed record
          for (i = hit; i + 1 < shadow_count; i++) begin
            shadow_key[i]     = shadow_key[i + 1];
            shadow_year[i]    = shadow_year[i + 1];
            shadow_courses[i] = shadow_courses[i + 1];
            shadow_grades[i]  = shadow_grades[i + 1];
          end
          shadow_count--;
          r.status = STATUS_OK;
        end
      end
    endcase
    expected_results_q.push_back(stamp_occupancy(r));
  endfunction

  function automatic string fmt_result(krt_out_t r);
    return $sformatf("st=%0d yr=%h crs=%h grd=%h key=%h last=%b cnt=%0d fill=%0d",
                     r.status, r.year_out, r.courses_out, r.grades_out,
                     r.listed_key, r.last, r.used_count, r.fill_state);
  endfunction

  // Compare one output transfer against the oldest prediction
  function automatic void check_result(krt_out_t got);
    krt_out_t want;
    string    wrong;
    result_index++;
    if (expected_results_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("krt_checker: result %0d with nothing expected: %s",
                 result_index, fmt_result(got));
      return;
    end
    want  = expected_results_q.pop_front();
    wrong = "";
    if (got.status      !== want.status)      wrong = {wrong, " status"};
    if (got.year_out    !== want.year_out)    wrong = {wrong, " year_out"};
    if (got.courses_out !== want.courses_out) wrong = {wrong, " courses_out"};
    if (got.grades_out  !== want.grades_out)  wrong = {wrong, " grades_out"};
    if (got.listed_key  !== want.listed_key)  wrong = {wrong, " listed_key"};
    if (got.last        !== want.last)        wrong = {wrong, " last"};
    if (got.used_count  !== want.used_count)  wrong = {wrong, " used_count"};
    if (got.fill_state  !== want.fill_state)  wrong = {wrong, " fill_state"};
    if (wrong != "") begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("krt_checker: result %0d wrong:%s\n  want %s\n  got  %s",
                 result_index, wrong, fmt_result(want), fmt_result(got));
    end
  endfunction

  // Watch both channels; inputs are predicted before outputs are checked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      expected_results_q.delete();
      result_index = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_table_op(in_i);
      if (out_valid_i && !out_stall_i) check_result(out_i);
      pending_o = expected_results_q.size();
    end
  end

endmodule

### verif/tb_keyed_record_table_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_record_table_top: testbench of the keyed record table
// Drives a directed opening, a fill-to-full burst and random segments of add,
// delete, read and list with random idles and stalls on both channels, one
// long output hold-off and one drain pause. krt_checker does all checking.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_top;
  import krt_pkg::*;

  localparam int RANDOM_ITEMS     = 440;
  localparam int IDLE_PCT         = 19;
  localparam int HOLD_AT_ITEM     = 150;
  localparam int HOLD_CYCLES      = 90;
  localparam int PAUSE_AT_ITEM    = 230;
  localparam int SEND_STEADY_FROM = 280;
  localparam int SEND_STEADY_TO   = 340;
  localparam int RECV_STEADY_FROM = 340;
  localparam int RECV_STEADY_TO   = 400;
  localparam int QUIET_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 40;

  // Segment flavors of the random part
  typedef enum logic [1:0] {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIX
  } seg_kind_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  krt_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  krt_out_t    out_item;
  int unsigned fail_count;
  int unsigned results_pending;
  int          items_sent;

  keyed_record_table_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  krt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_item),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic krt_in_t mk_item(krt_mode_e mode, logic [7:0] key, logic [7:0] year,
                                      logic [31:0] courses, logic [31:0] grades);
    krt_in_t item;
    item.mode       = mode;
    item.key        = key;
    item.year_in    = year;
    item.courses_in = courses;
    item.grades_in  = grades;
    return item;
  endfunction

  // Operation mix per segment flavor; list and read share the remainder
  function automatic krt_mode_e pick_mode(seg_kind_e kind);
    int unsigned roll;
    int unsigned add_pct;
    int unsigned del_pct;
    roll = $urandom_range(99);
    case (kind)
      SEG_FILL:  begin add_pct = 60; del_pct = 10; end
      SEG_DRAIN: begin add_pct = 15; del_pct = 55; end
      default:   begin add_pct = 35; del_pct = 30; end
    endcase
    if (roll < add_pct) return MODE_ADD;
    if (roll < add_pct + del_pct) return MODE_DELETE;
    if (roll < 90) return MODE_READ;
    return MODE_LIST;
  endfunction

  // Keys cluster around the segment base so lookups hit often
  function automatic krt_in_t random_item(seg_kind_e kind, logic [7:0] key_base);
    logic [7:0] key;
    if ($urandom_range(99) < 10) key = 8'($urandom);
    else key = key_base ^ 8'($urandom_range(7));
    return mk_item(pick_mode(kind), key, 8'($urandom), $urandom, $urandom);
  endfunction

  // One input transfer; starts and ends on a falling edge
  task automatic send_item(krt_in_t item);
    if (items_sent < SEND_STEADY_FROM || items_sent >= SEND_STEADY_TO) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Output side: random stalls, one long hold-off, one steady stretch
  initial begin : receiver
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (items_sent >= RECV_STEADY_FROM && items_sent < RECV_STEADY_TO)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Ends the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_keyed_record_table_top: errors");
    $finish;
  end

  initial begin : stimulus
    seg_kind_e  kind;
    logic [7:0] key_base;
    int         seg_left;
    int         n;
    bit         paused;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    items_sent = 0;
    paused     = 1'b0;
    seg_left   = 0;
    kind       = SEG_MIX;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, field extremes, duplicates, head and middle delete
    send_item(mk_item(MODE_LIST,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'hFF, 8'hFF, '1, '1));
    send_item(mk_item(MODE_ADD,    8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000));
    send_item(mk_item(MODE_ADD,    8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(MODE_ADD,    8'hA5, 8'h5A, 32'h1234_5678, 32'h9ABC_DEF0));
    send_item(mk_item(MODE_ADD,    8'hA5, 8'h11, 32'hCAFE_0001, 32'h0BAD_F00D));
    send_item(mk_item(MODE_READ,   8'hA5, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'hFF, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'h3C, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'h3C, 8'h00, '0, '0));
    send_item(mk_item(MODE_LIST,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'hA5, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'hA5, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'hFF, 8'h00, '0, '0));
    send_item(mk_item(MODE_LIST,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_DELETE, 8'hA5, 8'h00, '0, '0));
    send_item(mk_item(MODE_LIST,   8'h00, 8'h00, '0, '0));
    send_item(mk_item(MODE_READ,   8'hA5, 8'h00, '0, '0));

    // Fill past capacity so add reports full, then list the whole table
    key_base = 8'($urandom);
    for (n = 0; n < CAPACITY + 2; n++)
      send_item(mk_item(MODE_ADD, key_base ^ 8'(n), 8'($urandom), $urandom, $urandom));
    send_item(mk_item(MODE_LIST, 8'h00, 8'h00, '0, '0));

    // Random segments
    for (n = CAPACITY + 3; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(2))
          0:       kind = SEG_FILL;
          1:       kind = SEG_DRAIN;
          default: kind = SEG_MIX;
        endcase
        key_base = 8'($urandom);
        seg_left = $urandom_range(10, 40);
      end
      if (!paused && items_sent >= PAUSE_AT_ITEM) begin
        // sender waits until every predicted result has come out
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0) @(negedge clk);
      end
      send_item(random_item(kind, key_base));
      seg_left--;
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_keyed_record_table_top: clean");
    end else begin
      $display("tb_keyed_record_table_top: errors");
    end
    $finish;
  end

endmodule
